[rtl/tsa_pkg.sv]
package tsa_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int OFFSET_W   = 18;
  localparam int SLOPE_W    = 20;
  localparam int PROD_W     = SAMPLE_W + SLOPE_W;
  localparam int PROD_SHIFT = 11;
  localparam int TEMP_W     = 20;
  localparam int CONV_W     = 23;
  localparam int WSUM_W     = 27;
  localparam int TSUM_W     = 56;
  localparam int TCNT_W     = 32;
  localparam int QUO_W      = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 18'd111930;
  localparam logic [SLOPE_W-1:0]  SLOPE_RESET  = 20'd245439;

  // Most negative temperature code; results below it saturate here.
  localparam logic [TEMP_W-1:0] TEMP_MIN = {1'b1, {(TEMP_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET = 2'd0,
    CFG_SLOPE  = 2'd1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_CONV,
    S_ACC,
    S_WSTART,
    S_WWAIT,
    S_TSTART,
    S_TWAIT,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load_in;
    logic mul;
    logic conv;
    logic acc;
    logic div_start;
    logic div_sel_total;
    logic cap_win;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } status_t;

endpackage

[rtl/tsa_ram.sv]
module tsa_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 10
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/tsa_div.sv]
module tsa_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [tsa_pkg::TSUM_W-1:0]       dividend,
  input  logic [tsa_pkg::TCNT_W-1:0]       divisor,
  output logic                             done,
  output logic [tsa_pkg::QUO_W-1:0]        quotient
);

  localparam int CNT_W = $clog2(tsa_pkg::QUO_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(tsa_pkg::QUO_W - 1);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic                          neg;
  logic [tsa_pkg::TCNT_W-1:0]    dsr;
  logic [tsa_pkg::TCNT_W-1:0]    rem;
  logic [tsa_pkg::QUO_W-1:0]     qsh;
  logic [tsa_pkg::TSUM_W-1:0]    mag;
  logic [tsa_pkg::TCNT_W:0]      rem_sh;
  logic                          ge;
  logic [tsa_pkg::TCNT_W:0]      rem_diff;

  // Magnitude fits below divisor * 2**QUO_W, so the top bits start the remainder.
  assign mag      = dividend[tsa_pkg::TSUM_W-1] ? (~dividend + 1'b1) : dividend;
  assign rem_sh   = {rem, qsh[tsa_pkg::QUO_W-1]};
  assign ge       = rem_sh >= {1'b0, dsr};
  assign rem_diff = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[tsa_pkg::TSUM_W-1];
      dsr <= divisor;
      rem <= mag[tsa_pkg::QUO_W +: tsa_pkg::TCNT_W];
      qsh <= mag[tsa_pkg::QUO_W-1:0];
    end else if (busy) begin
      rem <= ge ? rem_diff[tsa_pkg::TCNT_W-1:0] : rem_sh[tsa_pkg::TCNT_W-1:0];
      qsh <= {qsh[tsa_pkg::QUO_W-2:0], ge};
    end
  end

  assign quotient = neg ? (~qsh + 1'b1) : qsh;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a running division");

  a_no_start_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !start)
    else $error("divider restarted while busy");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> rem < dsr)
    else $error("divider remainder not below divisor");

endmodule

[rtl/tsa_ctrl.sv]
module tsa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tsa_pkg::status_t status,
  output tsa_pkg::cmd_t    cmd
);

  tsa_pkg::state_t state;
  tsa_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      tsa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = tsa_pkg::S_MUL;
        end
      end
      tsa_pkg::S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = tsa_pkg::S_CONV;
      end
      tsa_pkg::S_CONV: begin
        cmd.conv   = 1'b1;
        state_next = tsa_pkg::S_ACC;
      end
      tsa_pkg::S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = tsa_pkg::S_WSTART;
      end
      tsa_pkg::S_WSTART: begin
        cmd.div_start = 1'b1;
        state_next    = tsa_pkg::S_WWAIT;
      end
      tsa_pkg::S_WWAIT: begin
        if (status.div_done) begin
          cmd.cap_win = 1'b1;
          state_next  = tsa_pkg::S_TSTART;
        end
      end
      tsa_pkg::S_TSTART: begin
        cmd.div_start     = 1'b1;
        cmd.div_sel_total = 1'b1;
        state_next        = tsa_pkg::S_TWAIT;
      end
      tsa_pkg::S_TWAIT: begin
        if (status.div_done) begin
          state_next = tsa_pkg::S_FIN;
        end
      end
      tsa_pkg::S_FIN: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = tsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tsa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/tsa_dp.sv]
module tsa_dp #(
  parameter int WINDOW = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  tsa_pkg::cmd_t                      cmd,
  output tsa_pkg::status_t                   status,
  input  logic                               cfg_valid,
  input  logic [tsa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tsa_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [tsa_pkg::SAMPLE_W-1:0]       adc_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [tsa_pkg::TEMP_W-1:0]  temperature,
  output logic signed [tsa_pkg::TEMP_W-1:0]  window_average,
  output logic signed [tsa_pkg::TEMP_W-1:0]  overall_average
);

  localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(WINDOW - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW);
  localparam int TW = tsa_pkg::TEMP_W;
  localparam int WSUM_W_L = tsa_pkg::WSUM_W;
  localparam logic signed [tsa_pkg::CONV_W-1:0] CONV_MIN =
    {{(tsa_pkg::CONV_W-TW){1'b1}}, tsa_pkg::TEMP_MIN};

  logic [tsa_pkg::OFFSET_W-1:0] temp_offset;
  logic [tsa_pkg::SLOPE_W-1:0]  temp_slope;
  logic [tsa_pkg::SAMPLE_W-1:0] sample;
  logic [tsa_pkg::PROD_W-1:0]   product;
  logic [TW-1:0]                old_entry;
  logic [TW-1:0]                temp;
  logic [WSUM_W_L-1:0]          window_sum;
  logic [PTR_W-1:0]             write_pointer;
  logic [FILL_W-1:0]            fill_count;
  logic [tsa_pkg::TSUM_W-1:0]   total_sum;
  logic [tsa_pkg::TCNT_W-1:0]   total_count;
  logic [TW-1:0]                win_avg;

  logic [TW-1:0]                     ram_rdata;
  logic signed [tsa_pkg::CONV_W-1:0] conv_diff;
  logic [TW-1:0]                     temp_next;
  logic                              ring_full;
  logic [tsa_pkg::TSUM_W-1:0]        div_dividend;
  logic [tsa_pkg::TCNT_W-1:0]        div_divisor;
  logic                              div_done;
  logic [tsa_pkg::QUO_W-1:0]         div_quotient;

  // Configuration registers; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_offset <= tsa_pkg::OFFSET_RESET;
      temp_slope  <= tsa_pkg::SLOPE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tsa_pkg::CFG_OFFSET: temp_offset <= cfg_data[tsa_pkg::OFFSET_W-1:0];
        tsa_pkg::CFG_SLOPE:  temp_slope  <= cfg_data[tsa_pkg::SLOPE_W-1:0];
        default: ;
      endcase
    end
  end

  // Slots at and past the fill count were never written: they read as zero.
  assign ring_full = fill_count == FILL_MAX;
  assign conv_diff = $signed({5'b0, temp_offset})
                   - $signed({2'b0, product[tsa_pkg::PROD_W-1:tsa_pkg::PROD_SHIFT]});
  assign temp_next = (conv_diff < CONV_MIN) ? tsa_pkg::TEMP_MIN : conv_diff[TW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sample <= adc_sample;
    end
    if (cmd.mul) begin
      product   <= tsa_pkg::PROD_W'(sample) * tsa_pkg::PROD_W'(temp_slope);
      old_entry <= ring_full ? ram_rdata : '0;
    end
    if (cmd.conv) begin
      temp <= temp_next;
    end
    if (cmd.cap_win) begin
      win_avg <= div_quotient;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum    <= '0;
      write_pointer <= '0;
      fill_count    <= '0;
      total_sum     <= '0;
      total_count   <= '0;
    end else if (cmd.acc) begin
      window_sum <= window_sum
                  - {{(WSUM_W_L-TW){old_entry[TW-1]}}, old_entry}
                  + {{(WSUM_W_L-TW){temp[TW-1]}}, temp};
      write_pointer <= (write_pointer == PTR_LAST) ? '0 : write_pointer + 1'b1;
      if (!ring_full) begin
        fill_count <= fill_count + 1'b1;
      end
      if (total_count != '1) begin
        total_sum   <= total_sum + {{(tsa_pkg::TSUM_W-TW){temp[TW-1]}}, temp};
        total_count <= total_count + 1'b1;
      end
    end
  end

  tsa_ram #(
    .WIDTH (TW),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.acc),
    .waddr (write_pointer),
    .wdata (temp),
    .re    (cmd.load_in),
    .raddr (write_pointer),
    .rdata (ram_rdata)
  );

  assign div_dividend = cmd.div_sel_total ? total_sum
                      : {{(tsa_pkg::TSUM_W-WSUM_W_L){window_sum[WSUM_W_L-1]}}, window_sum};
  assign div_divisor  = cmd.div_sel_total ? total_count
                      : tsa_pkg::TCNT_W'(fill_count);

  tsa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      temperature     <= temp;
      window_average  <= win_avg;
      overall_average <= div_quotient;
    end
  end

  assign status.div_done = div_done;
  assign status.out_free = !out_valid || out_ready;

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_MAX)
    else $error("fill count past window size");

  a_ptr_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    !ring_full |-> write_pointer == PTR_W'(fill_count))
    else $error("write pointer out of step with fill count");

  a_ptr_bounded: assert property (@(posedge clk) disable iff (rst)
    write_pointer <= PTR_LAST)
    else $error("write pointer past last slot");

endmodule

[rtl/temperature_sample_averager.sv]
// Channel   Handshake                Payload
// in        in_valid / in_ready      adc_sample[11:0]
// out       out_valid / out_ready    temperature, window_average, overall_average [19:0]
// cfg       cfg_valid / cfg_ready    cfg_index[1:0] (0 offset, 1 slope), cfg_data[19:0]
//
// Flow: a new input transaction is accepted only in the idle state, after the
//   last one has been handed to the output register; the shared 20-step restoring
//   divider, run once for each average, takes up most of each transaction.
// Reset: rst is synchronous; it clears the ring fill count, the sums and the
//   control state, and loads the default offset and slope.
// Stalls: a finished result waits in the output register while the next
//   transaction is accepted; the new result holds in the final state until
//   the output register frees up.
module temperature_sample_averager #(
  parameter int WINDOW = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tsa_pkg::SAMPLE_W-1:0]      adc_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tsa_pkg::TEMP_W-1:0] temperature,
  output logic signed [tsa_pkg::TEMP_W-1:0] window_average,
  output logic signed [tsa_pkg::TEMP_W-1:0] overall_average,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tsa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tsa_pkg::CFG_DATA_W-1:0]    cfg_data
);

  tsa_pkg::cmd_t    cmd;
  tsa_pkg::status_t status;

  // Register writes go straight into the configuration registers, so the port never stalls.
  assign cfg_ready = 1'b1;

  // Controller: sequence load, multiply, convert, accumulate, two divides,
  // then hand the transaction to the output register.
  tsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: conversion, ring memory, window and total sums, divider,
  // output register.
  tsa_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .adc_sample      (adc_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .temperature     (temperature),
    .window_average  (window_average),
    .overall_average (overall_average)
  );

endmodule

[tb/temperature_sample_averager_checker.sv]
module temperature_sample_averager_checker #(
  parameter int WINDOW = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [tsa_pkg::SAMPLE_W-1:0]      adc_sample,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [tsa_pkg::TEMP_W-1:0] temperature,
  input  logic signed [tsa_pkg::TEMP_W-1:0] window_average,
  input  logic signed [tsa_pkg::TEMP_W-1:0] overall_average,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [tsa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tsa_pkg::CFG_DATA_W-1:0]    cfg_data,
  output int                                outstanding,
  output int                                fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint TEMP_LO = -(longint'(1) << (tsa_pkg::TEMP_W - 1));
  localparam longint TEMP_HI = (longint'(1) << (tsa_pkg::TEMP_W - 1)) - 1;
  localparam logic [tsa_pkg::TCNT_W-1:0] COUNT_FULL = '1;
  localparam int     REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [tsa_pkg::TEMP_W-1:0] temp;
    logic signed [tsa_pkg::TEMP_W-1:0] win_avg;
    logic signed [tsa_pkg::TEMP_W-1:0] all_avg;
  } reading_t;

  logic [tsa_pkg::OFFSET_W-1:0]      offset_q;
  logic [tsa_pkg::SLOPE_W-1:0]       slope_q;
  logic signed [tsa_pkg::TEMP_W-1:0] ring [WINDOW];
  logic signed [tsa_pkg::WSUM_W-1:0] ring_sum;
  int                                ring_slot;
  int                                ring_fill;
  logic signed [tsa_pkg::TSUM_W-1:0] run_sum;
  logic [tsa_pkg::TCNT_W-1:0]        run_count;
  reading_t                          expected_readings [$];
  int                                reported = 0;

  // Convert a raw code with the current offset and slope, clamped to the field range.
  function automatic logic signed [tsa_pkg::TEMP_W-1:0] convert_reading(
    input logic [tsa_pkg::SAMPLE_W-1:0] code);
    logic [tsa_pkg::PROD_W-1:0] product;
    longint                     t;
    product = tsa_pkg::PROD_W'(code) * tsa_pkg::PROD_W'(slope_q);
    t = longint'(offset_q) - longint'(product >> tsa_pkg::PROD_SHIFT);
    if (t < TEMP_LO) t = TEMP_LO;
    if (t > TEMP_HI) t = TEMP_HI;
    return tsa_pkg::TEMP_W'(t);
  endfunction

  // Advance the ring and the running totals by one reading.
  function automatic reading_t predict_reading(input logic [tsa_pkg::SAMPLE_W-1:0] code);
    logic signed [tsa_pkg::TEMP_W-1:0] temp;
    reading_t                          r;
    temp = convert_reading(code);
    ring_sum = ring_sum - ring[ring_slot] + temp;
    ring[ring_slot] = temp;
    ring_slot = (ring_slot == WINDOW - 1) ? 0 : ring_slot + 1;
    if (ring_fill < WINDOW) ring_fill++;
    // Freeze the cumulative totals once the count is full.
    if (run_count != COUNT_FULL) begin
      run_sum = run_sum + temp;
      run_count = run_count + 1'b1;
    end
    r.temp    = temp;
    r.win_avg = tsa_pkg::TEMP_W'(longint'(ring_sum) / longint'(ring_fill));
    r.all_avg = tsa_pkg::TEMP_W'(longint'(run_sum) / longint'(run_count));
    return r;
  endfunction

  task automatic check_reading();
    reading_t want;
    if (expected_readings.size() == 0) begin
      fail_count++;
      if (reported < REPORT_LIMIT) begin
        reported++;
        $display("%0t: unexpected reading temp %0d win %0d all %0d", $time,
                 temperature, window_average, overall_average);
      end
    end else begin
      want = expected_readings.pop_front();
      if (want.temp !== temperature || want.win_avg !== window_average ||
          want.all_avg !== overall_average) begin
        fail_count++;
        if (reported < REPORT_LIMIT) begin
          reported++;
          $display("%0t: reading mismatch: expected temp %0d win %0d all %0d, got %0d %0d %0d",
                   $time, $signed(want.temp), $signed(want.win_avg), $signed(want.all_avg),
                   temperature, window_average, overall_average);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      offset_q  = tsa_pkg::OFFSET_RESET;
      slope_q   = tsa_pkg::SLOPE_RESET;
      foreach (ring[i]) ring[i] = '0;
      ring_sum  = '0;
      ring_slot = 0;
      ring_fill = 0;
      run_sum   = '0;
      run_count = '0;
      expected_readings.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tsa_pkg::CFG_OFFSET: offset_q = cfg_data[tsa_pkg::OFFSET_W-1:0];
          tsa_pkg::CFG_SLOPE:  slope_q = cfg_data[tsa_pkg::SLOPE_W-1:0];
          default: ;  // drop writes to unused indexes
        endcase
      end
      // Retire results before queuing new ones from the same edge.
      if (out_valid && out_ready) check_reading();
      if (in_valid && in_ready) expected_readings.push_back(predict_reading(adc_sample));
    end
    outstanding <= expected_readings.size();
  end

endmodule

[tb/tb_temperature_sample_averager.sv]
module tb_temperature_sample_averager;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW       = 10;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int TAIL_CYCLES  = 150;
  localparam int PHASE_COUNT  = 8;
  localparam int PHASE_ITEMS  = 178;

  // Indexes past the register list; writes there must leave the settings alone.
  localparam logic [tsa_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [tsa_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam logic [tsa_pkg::OFFSET_W-1:0] OFFSET_TOP = '1;
  localparam logic [tsa_pkg::SLOPE_W-1:0]  SLOPE_TOP  = '1;

  // Field extremes, alternating bit patterns, and enough entries to wrap the ring.
  localparam logic [tsa_pkg::SAMPLE_W-1:0] CORNER_CODES [12] = '{
    12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'h001, 12'h800,
    12'hFFE, 12'h7FF, 12'h064, 12'hBB8, 12'hFFF, 12'h000
  };

  logic                              clk        = 1'b0;
  logic                              rst        = 1'b1;
  logic                              in_valid   = 1'b0;
  logic                              in_ready;
  logic [tsa_pkg::SAMPLE_W-1:0]      adc_sample = '0;
  logic                              out_valid;
  logic                              out_ready  = 1'b0;
  logic signed [tsa_pkg::TEMP_W-1:0] temperature;
  logic signed [tsa_pkg::TEMP_W-1:0] window_average;
  logic signed [tsa_pkg::TEMP_W-1:0] overall_average;
  logic                              cfg_valid  = 1'b0;
  logic                              cfg_ready;
  logic [tsa_pkg::CFG_IDX_W-1:0]     cfg_index  = tsa_pkg::CFG_OFFSET;
  logic [tsa_pkg::CFG_DATA_W-1:0]    cfg_data   = '0;

  int outstanding;
  int fail_count;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  always #4 clk = ~clk;

  temperature_sample_averager #(
    .WINDOW(WINDOW)
  ) u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .adc_sample     (adc_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .temperature    (temperature),
    .window_average (window_average),
    .overall_average(overall_average),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  temperature_sample_averager_checker #(
    .WINDOW(WINDOW)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .adc_sample     (adc_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .temperature    (temperature),
    .window_average (window_average),
    .overall_average(overall_average),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .outstanding    (outstanding),
    .fail_count     (fail_count)
  );

  // Stall the result channel at the rate of the current phase; zero means always ready.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL temperature_sample_averager");
      $finish;
    end
  end

  // Offer one sample; return at the edge where the transaction is taken, valid still high,
  // so a back-to-back sample keeps valid up without a drop in between.
  task automatic send_sample(input logic [tsa_pkg::SAMPLE_W-1:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    adc_sample <= code;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off the sender until every predicted reading has come back.
  task automatic drain_readings();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Write one register, then advance one edge so the next write never re-raises
  // valid in the step where it was lowered.
  task automatic write_register(input logic [tsa_pkg::CFG_IDX_W-1:0] idx,
                                input logic [tsa_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offset has fewer bits than the data bus; randomize the bits above it.
  task automatic load_settings(input logic [tsa_pkg::OFFSET_W-1:0] offset,
                               input logic [tsa_pkg::SLOPE_W-1:0] slope);
    write_register(tsa_pkg::CFG_OFFSET,
                   {(tsa_pkg::CFG_DATA_W - tsa_pkg::OFFSET_W)'($urandom), offset});
    write_register(tsa_pkg::CFG_SLOPE, slope);
  endtask

  initial begin
    logic [tsa_pkg::SAMPLE_W-1:0] code;
    logic [tsa_pkg::OFFSET_W-1:0] offset;
    logic [tsa_pkg::SLOPE_W-1:0]  slope;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part, no idling. Start on reset settings so the first readings
    // also cover the window filling up from empty.
    foreach (CORNER_CODES[i]) send_sample(CORNER_CODES[i]);
    drain_readings();

    // Write past the register list; the next readings must still use reset settings.
    write_register(CFG_SPARE_LO, 20'($urandom));
    write_register(CFG_SPARE_HI, 20'($urandom));
    send_sample(12'h9C4);
    send_sample(12'h321);
    drain_readings();

    // Steepest slope: the top code drives the result below the field and clamps it,
    // code zero gives the highest temperature.
    load_settings(OFFSET_TOP, SLOPE_TOP);
    send_sample(12'hFFF);
    send_sample(12'h000);
    send_sample(12'h800);
    drain_readings();

    // Zero settings: every reading is zero.
    load_settings('0, '0);
    send_sample(12'hFFF);
    send_sample(12'h001);
    drain_readings();

    // Flat slope at the top offset: the highest temperature for any code.
    load_settings(OFFSET_TOP, '0);
    send_sample(12'h5A5);
    drain_readings();

    // Random part: cycle the idling modes twice across a spread of settings.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct = 78;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct <= 78;
        end
        default: begin
          send_idle_pct = 29;
          recv_stall_pct <= 29;
        end
      endcase

      case (phase)
        0: begin
          offset = tsa_pkg::OFFSET_RESET;
          slope  = tsa_pkg::SLOPE_RESET;
        end
        2: begin
          offset = OFFSET_TOP;
          slope  = SLOPE_TOP;
        end
        3: begin
          // Stay near a realistic sensor calibration.
          offset = 18'($urandom_range(90000, 130000));
          slope  = 20'($urandom_range(200000, 300000));
        end
        4: begin
          // Zero offset keeps every temperature at or below zero.
          offset = '0;
          slope  = 20'($urandom);
        end
        5: begin
          offset = OFFSET_TOP;
          slope  = 20'($urandom);
        end
        default: begin
          offset = 18'($urandom);
          slope  = 20'($urandom);
        end
      endcase
      load_settings(offset, slope);

      repeat (PHASE_ITEMS) begin
        // Lean on the code extremes now and then; otherwise uniform.
        case ($urandom_range(7))
          0:       code = '0;
          1:       code = '1;
          default: code = 12'($urandom_range(4095));
        endcase
        send_sample(code);
        // Occasionally let the block run dry before the next sample.
        if ($urandom_range(49) == 0) drain_readings();
      end
      drain_readings();
    end

    // Catch any stray result after the last expected one.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS temperature_sample_averager");
    end else begin
      $display("FAIL temperature_sample_averager");
    end
    $finish;
  end

endmodule
